// ----- hw/rtl/fwdm_pkg.sv -----
// ----------------------------------------------------------------------------
// fwdm_pkg
// Shared widths, codes and the cell control struct for the handle queue.
// ----------------------------------------------------------------------------
package fwdm_pkg;

    localparam int DEPTH_DEF = 16;
    localparam int DATA_W    = 32;
    localparam int MODE_W    = 2;
    localparam int STATUS_W  = 3;

    typedef enum logic [MODE_W-1:0] {
        MODE_ENQ = 2'd0,
        MODE_DEQ = 2'd1,
        MODE_DEL = 2'd2,
        MODE_NOP = 2'd3
    } t_mode;

    localparam logic [STATUS_W-1:0] ST_OK       = 3'd0;
    localparam logic [STATUS_W-1:0] ST_NULL     = 3'd1;
    localparam logic [STATUS_W-1:0] ST_EMPTY    = 3'd2;
    localparam logic [STATUS_W-1:0] ST_FULL     = 3'd3;
    localparam logic [STATUS_W-1:0] ST_NOTFOUND = 3'd4;

    // control broadcast to every cell of the chain
    typedef struct packed {
        logic              match_en;
        logic              remove_en;
        logic              load_en;
        logic [DATA_W-1:0] handle;
    } t_cell_ctl;

endpackage

// ----- hw/rtl/fwdm_cell.sv -----
// ----------------------------------------------------------------------------
// fwdm_cell
// One queue slot: holds a handle, flags a match and shifts towards the front.
// ----------------------------------------------------------------------------
module fwdm_cell #(
    parameter int CNT_W = $clog2(fwdm_pkg::DEPTH_DEF + 1),
    parameter int IDX   = 0
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  fwdm_pkg::t_cell_ctl       i_ctl,
    input  logic [CNT_W-1:0]          i_count,
    input  logic [fwdm_pkg::DATA_W-1:0] i_next_slot,
    input  logic                      i_found,
    output logic [fwdm_pkg::DATA_W-1:0] o_slot,
    output logic                      o_found
);

    logic [fwdm_pkg::DATA_W-1:0] r_slot;
    logic                        r_match;
    logic                        occupied;
    logic                        load_here;

    assign occupied  = CNT_W'(IDX) < i_count;
    assign load_here = i_ctl.load_en && (CNT_W'(IDX) == i_count);

    // found ripples from the front: this cell and all behind the first hit shift
    assign o_found = i_found | r_match;
    assign o_slot  = r_slot;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_match <= 1'b0;
        end else if (i_ctl.match_en) begin
            r_match <= occupied && (r_slot == i_ctl.handle);
        end
    end

    always_ff @(posedge i_clk) begin
        if (load_here) begin
            r_slot <= i_ctl.handle;
        end else if (i_ctl.remove_en && o_found) begin
            r_slot <= i_next_slot;
        end
    end

endmodule

// ----- hw/rtl/fifo_with_delete_by_match.sv -----
// ----------------------------------------------------------------------------
// fifo_with_delete_by_match
// Bounded queue of nonzero handles with enqueue, dequeue and delete by match.
// ----------------------------------------------------------------------------
//  channel | direction | handshake               | payload
//  --------+-----------+-------------------------+------------------------------
//  in      | to block  | i_in_valid / o_in_stall | i_mode, i_item_value
//  out     | from block| o_out_valid / i_out_stall| o_status, o_item_out, o_length
//
//  each request goes through accept, compare in every cell, then apply
//  the apply cycle waits while the output register holds an untaken result
//  the next request is taken while a result still waits at the output
//  the first-match flag ripples through the cell chain in the apply cycle
//  synchronous reset empties the queue; slot contents are not cleared
// ----------------------------------------------------------------------------
module fifo_with_delete_by_match #(
    parameter int DEPTH = fwdm_pkg::DEPTH_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    output logic                                o_in_stall,
    input  logic [fwdm_pkg::MODE_W-1:0]         i_mode,
    input  logic [fwdm_pkg::DATA_W-1:0]         i_item_value,
    output logic                                o_out_valid,
    input  logic                                i_out_stall,
    output logic [fwdm_pkg::STATUS_W-1:0]       o_status,
    output logic [fwdm_pkg::DATA_W-1:0]         o_item_out,
    output logic [$clog2(DEPTH+1)-1:0]          o_length
);

    localparam int CNT_W = $clog2(DEPTH + 1);

    typedef enum logic [1:0] {
        S_IDLE,
        S_MATCH,
        S_APPLY
    } t_state;

    t_state                        r_state;
    fwdm_pkg::t_mode               r_mode;
    logic [fwdm_pkg::DATA_W-1:0]   r_handle;
    logic [CNT_W-1:0]              r_count;
    logic                          r_out_valid;
    logic [fwdm_pkg::STATUS_W-1:0] r_status;
    logic [fwdm_pkg::DATA_W-1:0]   r_item;
    logic [CNT_W-1:0]              r_len;

    logic                          in_take;
    logic                          apply_go;
    logic                          do_load;
    logic                          do_remove;
    logic [fwdm_pkg::STATUS_W-1:0] n_status;
    logic [fwdm_pkg::DATA_W-1:0]   n_item;
    logic [CNT_W-1:0]              n_count;
    logic                          handle_null;
    logic                          is_empty;
    logic                          is_full;
    fwdm_pkg::t_cell_ctl           cell_ctl;

    logic [fwdm_pkg::DATA_W-1:0]   w_slot  [DEPTH];
    logic                          w_found [DEPTH+1];

    assign o_in_stall = (r_state != S_IDLE);
    assign in_take    = i_in_valid && !o_in_stall;
    assign apply_go   = (r_state == S_APPLY) && (!r_out_valid || !i_out_stall);

    assign handle_null = (r_handle == '0);
    assign is_empty    = (r_count == '0);
    assign is_full     = (r_count == CNT_W'(DEPTH));

    always_comb begin
        n_status  = fwdm_pkg::ST_OK;
        n_item    = '0;
        do_load   = 1'b0;
        do_remove = 1'b0;
        case (r_mode)
            fwdm_pkg::MODE_ENQ: begin
                if (handle_null) begin
                    n_status = fwdm_pkg::ST_NULL;
                end else if (is_full) begin
                    n_status = fwdm_pkg::ST_FULL;
                end else begin
                    do_load = 1'b1;
                end
            end
            fwdm_pkg::MODE_DEQ: begin
                if (is_empty) begin
                    n_status = fwdm_pkg::ST_EMPTY;
                end else begin
                    do_remove = 1'b1;
                    n_item    = w_slot[0];
                end
            end
            fwdm_pkg::MODE_DEL: begin
                if (handle_null) begin
                    n_status = fwdm_pkg::ST_NULL;
                end else if (is_empty) begin
                    n_status = fwdm_pkg::ST_EMPTY;
                end else if (w_found[DEPTH]) begin
                    do_remove = 1'b1;
                end else begin
                    n_status = fwdm_pkg::ST_NOTFOUND;
                end
            end
            default: begin
            end
        endcase
    end

    always_comb begin
        n_count = r_count;
        if (do_load) begin
            n_count = r_count + CNT_W'(1);
        end else if (do_remove) begin
            n_count = r_count - CNT_W'(1);
        end
    end

    assign cell_ctl.match_en  = (r_state == S_MATCH);
    assign cell_ctl.remove_en = apply_go && do_remove;
    assign cell_ctl.load_en   = apply_go && do_load;
    assign cell_ctl.handle    = r_handle;

    // dequeue forces the shift from the front cell onwards
    assign w_found[0] = (r_mode == fwdm_pkg::MODE_DEQ);

    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        fwdm_cell #(
            .CNT_W (CNT_W),
            .IDX   (g)
        ) u_cell (
            .i_clk       (i_clk),
            .i_rst_n     (i_rst_n),
            .i_ctl       (cell_ctl),
            .i_count     (r_count),
            .i_next_slot (w_slot[(g + 1) % DEPTH]),
            .i_found     (w_found[g]),
            .o_slot      (w_slot[g]),
            .o_found     (w_found[g+1])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (in_take) begin
                        r_state <= S_MATCH;
                    end
                end
                S_MATCH: begin
                    r_state <= S_APPLY;
                end
                S_APPLY: begin
                    if (apply_go) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
            if (apply_go) begin
                r_count     <= n_count;
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_mode   <= fwdm_pkg::t_mode'(i_mode);
            r_handle <= i_item_value;
        end
        if (apply_go) begin
            r_status <= n_status;
            r_item   <= n_item;
            r_len    <= n_count;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_status    = r_status;
    assign o_item_out  = r_item;
    assign o_length    = r_len;

endmodule

// ----- hw/rtl/fwdm_checker.sv -----
// ----------------------------------------------------------------------------
// fwdm_checker
// Port-level checks on the handle queue, bound to the top level.
// ----------------------------------------------------------------------------
module fwdm_checker #(
    parameter int DEPTH = fwdm_pkg::DEPTH_DEF
) (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          i_in_valid,
    input logic                          o_in_stall,
    input logic                          o_out_valid,
    input logic                          i_out_stall,
    input logic [fwdm_pkg::STATUS_W-1:0] o_status,
    input logic [fwdm_pkg::DATA_W-1:0]   o_item_out,
    input logic [$clog2(DEPTH+1)-1:0]    o_length
);

    // a taken request keeps the input closed while it is worked on
    a_busy_after_take: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall |=> o_in_stall)
        else $error("input open right after a request was taken");

    // only a good dequeue returns a handle
    a_item_only_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_status != fwdm_pkg::ST_OK) |-> (o_item_out == '0))
        else $error("handle returned with an error status");

    // the length never exceeds DEPTH, and full and empty errors agree with it
    a_len_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_length <= ($clog2(DEPTH+1))'(DEPTH)) &&
            ((o_status != fwdm_pkg::ST_FULL) || (o_length == ($clog2(DEPTH+1))'(DEPTH))) &&
            ((o_status != fwdm_pkg::ST_EMPTY) || (o_length == '0)))
        else $error("length does not fit the status");

    a_hold_stalled: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_status) &&
            $stable(o_item_out) && $stable(o_length))
        else $error("stalled result changed");

endmodule

bind fifo_with_delete_by_match fwdm_checker #(
    .DEPTH (DEPTH)
) u_fwdm_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_stall  (o_in_stall),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_status    (o_status),
    .o_item_out  (o_item_out),
    .o_length    (o_length)
);

// ----- test/fifo_with_delete_by_match_checker.sv -----
// ----------------------------------------------------------------------------
// fifo_with_delete_by_match_checker
// Watches both channels of the handle queue, keeps its own copy of the queue,
// works out the expected status, removed handle and length for every accepted
// request and compares them field by field with the results in order.
// ----------------------------------------------------------------------------
module fifo_with_delete_by_match_checker
    import fwdm_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_in_valid,
    input  logic                         i_in_stall,
    input  logic [MODE_W-1:0]            i_mode,
    input  logic [DATA_W-1:0]            i_item_value,
    input  logic                         i_out_valid,
    input  logic                         i_out_stall,
    input  logic [STATUS_W-1:0]          i_status,
    input  logic [DATA_W-1:0]            i_item_out,
    input  logic [$clog2(DEPTH+1)-1:0]   i_length,
    output int                           o_fail_count,
    output int                           o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int LEN_W = $clog2(DEPTH + 1);

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [DATA_W-1:0]   item_out;
        logic [LEN_W-1:0]    length;
    } t_queue_result;

    logic [DATA_W-1:0] held_handles[$];
    t_queue_result     expected_results[$];
    int                fail_count = 0;

    initial begin
        o_fail_count = 0;
        o_pending = 0;
    end

    // applies one request to the held handles and returns what the block should report
    function automatic t_queue_result apply_request(t_mode mode, logic [DATA_W-1:0] handle);
        t_queue_result res;
        int hit;
        res = '0;
        res.status = ST_OK;
        hit = -1;
        case (mode)
            MODE_ENQ: begin
                if (handle == '0) begin
                    res.status = ST_NULL;
                end else if (held_handles.size() >= DEPTH) begin
                    res.status = ST_FULL;
                end else begin
                    held_handles.push_back(handle);
                end
            end
            MODE_DEQ: begin
                if (held_handles.size() == 0) begin
                    res.status = ST_EMPTY;
                end else begin
                    res.item_out = held_handles.pop_front();
                end
            end
            MODE_DEL: begin
                // null check wins over empty
                if (handle == '0) begin
                    res.status = ST_NULL;
                end else if (held_handles.size() == 0) begin
                    res.status = ST_EMPTY;
                end else begin
                    foreach (held_handles[k]) begin
                        if (hit < 0 && held_handles[k] == handle) begin
                            hit = k;
                        end
                    end
                    if (hit < 0) begin
                        res.status = ST_NOTFOUND;
                    end else begin
                        held_handles.delete(hit);
                    end
                end
            end
            default: ;
        endcase
        res.length = LEN_W'(held_handles.size());
        return res;
    endfunction

    function automatic void check_field(string field, logic [DATA_W-1:0] want,
                                        logic [DATA_W-1:0] got);
        if (want !== got) begin
            $error("%s: expected %0h, actual %0h", field, want, got);
            fail_count++;
        end
    endfunction

    always @(posedge i_clk) begin : watch
        t_queue_result want;
        if (!i_rst_n) begin
            held_handles.delete();
            expected_results.delete();
        end else begin
            // a result never belongs to the request taken at the same edge
            if (i_out_valid && !i_out_stall) begin
                if (expected_results.size() == 0) begin
                    $error("unexpected result: status %0h, item_out %0h, length %0h",
                           i_status, i_item_out, i_length);
                    fail_count++;
                end else begin
                    want = expected_results.pop_front();
                    check_field("status", DATA_W'(want.status), DATA_W'(i_status));
                    check_field("item_out", want.item_out, i_item_out);
                    check_field("length", DATA_W'(want.length), DATA_W'(i_length));
                end
            end
            if (i_in_valid && !i_in_stall) begin
                expected_results.push_back(apply_request(t_mode'(i_mode), i_item_value));
            end
        end
        o_fail_count <= fail_count;
        o_pending <= expected_results.size();
    end

endmodule

// ----- test/fifo_with_delete_by_match_tb.sv -----
// ----------------------------------------------------------------------------
// fifo_with_delete_by_match_tb
// Drives requests into the handle queue: a directed pass over empty, full,
// null, duplicate and missing handles, then random phases that lean towards
// filling, draining or balance, with random idling on both channels and one
// long receiver hold-off so the queue backs up. The checker does the scoring.
// ----------------------------------------------------------------------------
module fifo_with_delete_by_match_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import fwdm_pkg::*;

    localparam int DEPTH          = DEPTH_DEF;
    localparam int LEN_W          = $clog2(DEPTH + 1);
    localparam int ITEM_TARGET    = 1600;
    localparam int CALM_FROM      = 1400;
    localparam int PRESSURE_AT    = 600;
    localparam int HOLD_CYCLES    = 80;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int DRAIN_CYCLES   = 16;
    localparam int POOL_SIZE      = 8;

    logic                i_clk = 1'b0;
    logic                i_rst_n;
    logic                i_in_valid;
    logic                o_in_stall;
    logic [MODE_W-1:0]   i_mode;
    logic [DATA_W-1:0]   i_item_value;
    logic                o_out_valid;
    logic                i_out_stall;
    logic [STATUS_W-1:0] o_status;
    logic [DATA_W-1:0]   o_item_out;
    logic [LEN_W-1:0]    o_length;

    int fail_count;
    int pending;
    int sent = 0;
    int quiet_cycles = 0;
    int mode_hits[4] = '{default: 0};
    int status_hits[5] = '{default: 0};
    bit no_idle = 1'b0;
    bit sender_steady = 1'b0;
    bit hold_now = 1'b0;

    always #4ns i_clk = ~i_clk;

    fifo_with_delete_by_match #(
        .DEPTH (DEPTH)
    ) i_dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_stall   (o_in_stall),
        .i_mode       (i_mode),
        .i_item_value (i_item_value),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .o_status     (o_status),
        .o_item_out   (o_item_out),
        .o_length     (o_length)
    );

    fifo_with_delete_by_match_checker #(
        .DEPTH (DEPTH)
    ) i_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .i_in_stall   (o_in_stall),
        .i_mode       (i_mode),
        .i_item_value (i_item_value),
        .i_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .i_status     (o_status),
        .i_item_out   (o_item_out),
        .i_length     (o_length),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    // offers one request and holds it until taken, then maybe idles
    task automatic send_request(t_mode mode, logic [DATA_W-1:0] value);
        i_in_valid <= 1'b1;
        i_mode <= mode;
        i_item_value <= value;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        mode_hits[mode]++;
        sent++;
        if (!no_idle && !sender_steady && $urandom_range(0, 5) == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 17)) @(posedge i_clk);
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (i_rst_n && o_out_valid && !i_out_stall && o_status <= ST_NOTFOUND) begin
            status_hits[o_status]++;
        end
    end

    initial begin : watchdog
        while (quiet_cycles < WATCHDOG_LIMIT) @(posedge i_clk);
        $display("fifo_with_delete_by_match: mismatch");
        $finish;
    end

    // receiver: random stall bursts, free-running stretches and one long hold-off
    initial begin : receiver
        int  burst_left;
        bit  burst_stall;
        burst_left = 0;
        burst_stall = 1'b0;
        i_out_stall <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_now) begin
                hold_now = 1'b0;
                burst_stall = 1'b1;
                burst_left = HOLD_CYCLES;
            end else if (burst_left <= 0) begin
                burst_stall = ($urandom_range(0, 3) == 0);
                burst_left = burst_stall ? $urandom_range(1, 17) : $urandom_range(1, 40);
            end
            i_out_stall <= burst_stall && !no_idle;
            burst_left--;
        end
    end

    initial begin : stimulus
        logic [DATA_W-1:0] pool[POOL_SIZE];
        logic [DATA_W-1:0] rear_value;
        logic [DATA_W-1:0] value;
        t_mode             mode;
        int                bias;
        int                roll;
        bit                pressure_done;
        pressure_done = 1'b0;
        rear_value = '0;
        i_rst_n <= 1'b0;
        i_in_valid <= 1'b0;
        i_mode <= MODE_NOP;
        i_item_value <= '0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // empty queue, null handles, null checked before empty
        send_request(MODE_DEQ, 32'h0000_1234);
        send_request(MODE_DEL, 32'h0000_0005);
        send_request(MODE_ENQ, '0);
        send_request(MODE_DEL, '0);
        // fill with extremes and a duplicate, then overflow
        send_request(MODE_ENQ, '1);
        send_request(MODE_ENQ, 32'h0000_0001);
        send_request(MODE_ENQ, 32'h8000_0000);
        send_request(MODE_ENQ, '1);
        for (int k = 4; k < DEPTH; k++) begin
            rear_value = $urandom | 32'h1;
            send_request(MODE_ENQ, rear_value);
        end
        send_request(MODE_ENQ, 32'h0000_0007);
        // deletes: null, missing, first of duplicates, middle, rear
        send_request(MODE_DEL, '0);
        send_request(MODE_DEL, 32'h5A5A_5A5A);
        send_request(MODE_DEL, '1);
        send_request(MODE_DEL, 32'h8000_0000);
        send_request(MODE_DEL, rear_value);
        send_request(MODE_DEQ, '0);
        send_request(MODE_NOP, 32'hDEAD_BEEF);

        // random phases; small handle pools keep deletes hitting and duplicates common
        while (sent < ITEM_TARGET) begin
            bias = $urandom_range(0, 2);
            sender_steady = ($urandom_range(0, 3) == 0);
            foreach (pool[k]) begin
                pool[k] = ($urandom_range(0, 1) != 0) ? DATA_W'($urandom)
                                                      : DATA_W'($urandom_range(1, 15));
            end
            if (!pressure_done && sent >= PRESSURE_AT) begin
                // receiver holds off while requests keep coming, so the input backs up
                pressure_done = 1'b1;
                hold_now = 1'b1;
                repeat (DEPTH + 8) begin
                    send_request(MODE_ENQ, pool[$urandom_range(0, POOL_SIZE - 1)]);
                end
            end
            repeat ($urandom_range(30, 120)) begin
                no_idle = (sent >= CALM_FROM);
                roll = $urandom_range(0, 99);
                case (bias)
                    0: mode = roll < 60 ? MODE_ENQ : roll < 75 ? MODE_DEQ :
                              roll < 95 ? MODE_DEL : MODE_NOP;
                    1: mode = roll < 20 ? MODE_ENQ : roll < 65 ? MODE_DEQ :
                              roll < 95 ? MODE_DEL : MODE_NOP;
                    default: mode = roll < 35 ? MODE_ENQ : roll < 65 ? MODE_DEQ :
                                    roll < 95 ? MODE_DEL : MODE_NOP;
                endcase
                roll = $urandom_range(0, 99);
                value = roll < 4  ? '0 :
                        roll < 14 ? DATA_W'($urandom) :
                                    pool[$urandom_range(0, POOL_SIZE - 1)];
                send_request(mode, value);
            end
        end

        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("covered %0d requests: %0d enqueue, %0d dequeue, %0d delete, %0d no-op",
                 sent, mode_hits[MODE_ENQ], mode_hits[MODE_DEQ], mode_hits[MODE_DEL],
                 mode_hits[MODE_NOP]);
        $display("statuses seen: ok %0d, null %0d, empty %0d, full %0d, not found %0d",
                 status_hits[ST_OK], status_hits[ST_NULL], status_hits[ST_EMPTY],
                 status_hits[ST_FULL], status_hits[ST_NOTFOUND]);
        if (fail_count == 0) begin
            $display("fifo_with_delete_by_match: match");
        end else begin
            $display("fifo_with_delete_by_match: mismatch");
        end
        $finish;
    end

endmodule
